FILE: sv/mt64c_pkg.sv
// ---------------------------------------------------------------------------
// mt64c_pkg: shared types and constants of the MT19937-64 keystream cipher
// Generator constants, state word width and controller/datapath interface.
// ---------------------------------------------------------------------------
package mt64c_pkg;

  localparam int unsigned TW_N      = 312;
  localparam int unsigned TW_M      = 156;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned WORD_W    = 64;

  localparam logic [63:0] TW_MATRIX   = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TW_INIT_MUL = 64'd6364136223846793005;
  localparam logic [63:0] SEED_RESET  = 64'd12345;

  // Command from the controller to the datapath
  typedef struct packed {
    logic seed_start;   // load seed word and begin fill
    logic seed_step;    // advance one fill step
    logic twist_rd;     // issue reads for on-the-fly twist of current index
    logic twist_wr;     // write back twisted word and emit key byte
    logic clr_cnt;      // clear byte counter
  } mt64c_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic seed_done;    // fill sweep finished
    logic seeded;       // generator holds a valid state
  } mt64c_sts_t;

  // Tempering of one generator word (the shift-17 mask differs from MT19937-64)
  function automatic logic [63:0] temper(input logic [63:0] x);
    logic [63:0] y;
    y = x;
    y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
    y = y ^ ((y << 17) & 64'h71D6_7FFF_EEB3_0000);
    y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

FILE: sv/mt64c_ctrl.sv
// ---------------------------------------------------------------------------
// mt64c_ctrl: sequencing controller
// Handles input/output handshakes, seeding sweep and per-byte twist steps.
// ---------------------------------------------------------------------------
module mt64c_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_restart,
  output logic                   in_take,
  output logic                   out_load,
  input  logic                   out_busy,
  output mt64c_pkg::mt64c_cmd_t  cmd,
  input  mt64c_pkg::mt64c_sts_t  sts
);
  import mt64c_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEED = 4'b0010,
    S_READ = 4'b0100,
    S_WRIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_take   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_busy) begin
          in_take = 1'b1;
          if (in_restart || !sts.seeded) begin
            cmd.seed_start = 1'b1;
            cmd.clr_cnt    = 1'b1;
            state_nxt      = S_SEED;
          end else begin
            cmd.twist_rd = 1'b1;
            state_nxt    = S_WRIT;
          end
        end
      end
      S_SEED: begin
        if (sts.seed_done) begin
          state_nxt = S_READ;
        end else begin
          cmd.seed_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.twist_rd = 1'b1;
        state_nxt    = S_WRIT;
      end
      S_WRIT: begin
        cmd.twist_wr = 1'b1;
        out_load     = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/mt64c_dp.sv
// ---------------------------------------------------------------------------
// mt64c_dp: generator datapath
// State memory, seeding multiplier, on-the-fly twist, tempering and XOR.
// ---------------------------------------------------------------------------
module mt64c_dp #(
  parameter logic [63:0] SEED_RST = mt64c_pkg::SEED_RESET
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [63:0]            cfg_wdata,
  input  logic                   in_take,
  input  logic [7:0]             in_byte,
  input  mt64c_pkg::mt64c_cmd_t  cmd,
  output mt64c_pkg::mt64c_sts_t  sts,
  output logic [7:0]             key_out
);
  import mt64c_pkg::*;

  logic [63:0]      seed_r;
  logic [63:0]      mem [TW_N];
  logic [IDX_W-1:0] idx_r;       // word to produce next
  logic [IDX_W-1:0] fill_r;      // seeding write address
  logic [63:0]      prev_r;      // last seeded word
  logic [1:0]       fphase_r;    // seeding sub-step
  logic [63:0]      mul_r;       // seeding product accumulator
  logic             seeding_r;
  logic             seeded_r;
  logic [7:0]       cnt_r;
  logic [7:0]       data_r;
  logic [63:0]      rd_a_r, rd_b_r, rd_c_r;
  logic [IDX_W-1:0] ib, ic;
  logic [63:0]      xw, yw, neww;
  logic [63:0]      sx;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      tword;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  assign ib = (idx_r == IDX_W'(TW_N - 1)) ? '0 : idx_r + 1'b1;
  assign ic = (idx_r >= IDX_W'(TW_N - TW_M)) ? idx_r - IDX_W'(TW_N - TW_M)
                                              : idx_r + IDX_W'(TW_M);

  // twist of the word at idx_r
  assign xw   = (rd_a_r & 64'hFFFF_FFFF_8000_0000) | (rd_b_r & 64'h0000_0000_7FFF_FFFF);
  assign yw   = (xw >> 1) ^ (xw[0] ? TW_MATRIX : 64'd0);
  assign neww = rd_c_r ^ yw;

  // 32x32 partial products of the 64-bit seeding multiply, low half kept
  assign sx = prev_r ^ (prev_r >> 62);

  always_comb begin
    case (fphase_r)
      2'd0: begin
        mul_a = sx[31:0];
        mul_b = TW_INIT_MUL[31:0];
      end
      2'd1: begin
        mul_a = sx[63:32];
        mul_b = TW_INIT_MUL[31:0];
      end
      2'd2: begin
        mul_a = sx[31:0];
        mul_b = TW_INIT_MUL[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // seeding sweep: three multiply steps then add/write for each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeding_r <= 1'b0;
      seeded_r  <= 1'b0;
      fphase_r  <= '0;
    end else if (cmd.seed_start) begin
      seeding_r <= 1'b1;
      seeded_r  <= 1'b1;
      fill_r    <= IDX_W'(1);
      prev_r    <= seed_r;
      fphase_r  <= '0;
    end else if (cmd.seed_step && seeding_r) begin
      if (fphase_r == 2'd0) begin
        mul_r    <= mul_p;
        fphase_r <= 2'd1;
      end else if (fphase_r != 2'd3) begin
        mul_r[63:32] <= mul_r[63:32] + mul_p[31:0];
        fphase_r     <= fphase_r + 2'd1;
      end else begin
        prev_r   <= mul_r + 64'(fill_r);
        fphase_r <= 2'd0;
        if (fill_r == IDX_W'(TW_N - 1)) begin
          seeding_r <= 1'b0;
        end
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign sts.seed_done = !seeding_r;
  assign sts.seeded    = seeded_r;

  // state memory: one write port, two clocked reads
  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      mem[0] <= seed_r;
    end else if (cmd.seed_step && seeding_r && fphase_r == 2'd3) begin
      mem[fill_r] <= mul_r + 64'(fill_r);
    end else if (cmd.twist_wr) begin
      mem[idx_r] <= neww;
    end
    if (cmd.twist_rd) begin
      rd_b_r <= mem[ib];
      rd_c_r <= mem[ic];
    end
  end

  // upper-bit source of the next twist: seed word, then the last next-word read
  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      rd_a_r <= seed_r;
    end else if (cmd.twist_wr) begin
      rd_a_r <= rd_b_r;
    end
  end

  // index, counter and input byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.seed_start) begin
        idx_r <= '0;
      end else if (cmd.twist_wr) begin
        idx_r <= ib;
      end
      if (cmd.clr_cnt) begin
        cnt_r <= '0;
      end else if (cmd.twist_wr) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_r <= in_byte;
    end
  end

  assign tword   = temper(neww);
  assign key_out = data_r ^ tword[7:0] ^ cnt_r;

endmodule

FILE: sv/mt64_keystream_xor_cipher_top.sv
// ---------------------------------------------------------------------------
// mt64_keystream_xor_cipher_top: MT19937-64 keystream byte cipher
// Each byte is XORed with the low byte of the next generator output and a
// wrapping byte counter.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | tdata[7:0] data_byte, tuser[0] restart
//  out_    | out | tdata[7:0] out_byte
//  cfg_    | in  | wdata[63:0] key_seed
// A byte is accepted with state reads issued, then twisted and written back with
// output load, using one write port and two clocked reads on the state memory.
// A restart, or the first byte after reset, adds a seeding sweep through a
// 32x32 multiplier: three multiply steps and an add/write for each word.
// Reset: synchronous, rst_n low; seed returns to SEED_RST (default 12345).
// Output register holds a result while out_tready is low; no new byte starts.
module mt64_keystream_xor_cipher_top #(
  parameter logic [63:0] SEED_RST = mt64c_pkg::SEED_RESET
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tuser,     // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_byte
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import mt64c_pkg::*;

  mt64c_cmd_t cmd;
  mt64c_sts_t sts;
  logic       in_take, out_load, out_busy;
  logic [7:0] key_out;
  logic       ovalid_r;
  logic [7:0] odata_r;
  logic       idle_rdy;

  assign out_busy  = ovalid_r && !out_tready;
  assign in_tready = in_take;
  assign idle_rdy  = 1'b1;

  mt64c_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid  (in_tvalid && idle_rdy),
    .in_restart(in_tuser),
    .in_take, .out_load, .out_busy,
    .cmd, .sts
  );

  mt64c_dp #(.SEED_RST(SEED_RST)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_take, .in_byte(in_tdata),
    .cmd, .sts, .key_out
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= key_out;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

FILE: sv/mt64c_chk.sv
// ---------------------------------------------------------------------------
// mt64c_chk: port checker
// Watches handshakes of the cipher top level over time.
// ---------------------------------------------------------------------------
module mt64c_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  // held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  // no acceptance while a result is stuck
  a_no_take_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("byte taken while output stalled");

  // no accept on the cycle right after an accept
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back to back accept");

  // ready only with valid
  a_ready_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> in_tvalid)
    else $error("ready without valid");
endmodule

bind mt64_keystream_xor_cipher_top mt64c_chk u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
